[design/bnr_pkg.sv]
// bnr_pkg: shared constants, types and microcode for the Bezier parameter refiner.
// No dependencies; used by bnr_ctrl, bnr_dpath and the top level.
package bnr_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int PARAM_WIDTH_DEF = 20;

    localparam int ACC_W      = 48;
    localparam int COORD_FRAC = 8;
    localparam int PARAM_FRAC = 16;
    localparam int HALF_W     = ACC_W / 2;
    localparam int PROD_W     = 2 * ACC_W;
    localparam int DVD_W      = ACC_W + PARAM_FRAC;
    localparam int CNT_W      = $clog2(DVD_W);
    localparam int EXT_W      = ACC_W + 4;

    localparam int RF_DEPTH  = 32;
    localparam int RF_AW     = $clog2(RF_DEPTH);
    localparam int UCODE_LEN = 102;
    localparam int UPC_W     = $clog2(UCODE_LEN);

    localparam int CFG_NUM = 8;
    localparam int CFG_AW  = $clog2(CFG_NUM);
    localparam int K_W     = 4;
    localparam int SRC_PX  = 8;
    localparam int SRC_PY  = 9;

    localparam int T0_ADDR  = 9;
    localparam int T1_ADDR  = 19;
    localparam int NUM_IDX  = 20;
    localparam int DEN_IDX  = 21;
    localparam logic [RF_AW-1:0] NUM_ADDR = RF_AW'(NUM_IDX);
    localparam logic [RF_AW-1:0] DEN_ADDR = RF_AW'(DEN_IDX);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_LD,
        OP_SUB,
        OP_ADD,
        OP_X3,
        OP_X2,
        OP_MULU,
        OP_MUL8
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [RF_AW-1:0] dst;
        logic [RF_AW-1:0] a;
        logic [RF_AW-1:0] b;
        logic [K_W-1:0]   k;
    } ucode_t;

    typedef struct packed {
        logic             load;
        logic             exec;
        logic             mlo;
        logic             mhi;
        logic             mfin;
        logic             div_load;
        logic             div_step;
        logic             div_fin;
        logic             commit;
        logic [RF_AW-1:0] rd_a;
        logic [RF_AW-1:0] rd_b;
        ucode_t           uc;
    } cmd_t;

    typedef struct packed {
        logic den_zero;
        logic out_free;
    } stat_t;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [EXT_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > EXT_W'(ACC_MAX))
            r = ACC_MAX;
        else if (v < EXT_W'(ACC_MIN))
            r = ACC_MIN;
        else
            r = v[ACC_W-1:0];
        return r;
    endfunction

    function automatic ucode_t mk_uc(input op_t op, input int dst, input int a, input int b,
                                     input int k);
        ucode_t u;
        u.op  = op;
        u.dst = RF_AW'(dst);
        u.a   = RF_AW'(a);
        u.b   = RF_AW'(b);
        u.k   = K_W'(k);
        return u;
    endfunction

    // Per axis: load control points, derivative points, then de Casteljau lerps
    // (sub, multiply by u, add). Then residual, numerator and denominator.
    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] pc);
        ucode_t prog [UCODE_LEN];
        int     lp [10];
        int     n;
        int     b;
        lp = '{0, 1, 2, 0, 1, 0, 4, 5, 4, 7};
        n  = 0;
        for (int c = 0; c < 2; c++)
        begin
            b = 10 * c;
            for (int i = 0; i < 4; i++)
            begin
                prog[n] = mk_uc(OP_LD, b + i, 0, 0, 2 * i + c);
                n++;
            end
            for (int i = 0; i < 3; i++)
            begin
                prog[n] = mk_uc(OP_SUB, b + 4 + i, b + i + 1, b + i, 0);
                n++;
                prog[n] = mk_uc(OP_X3, b + 4 + i, b + 4 + i, 0, 0);
                n++;
            end
            for (int i = 0; i < 2; i++)
            begin
                prog[n] = mk_uc(OP_SUB, b + 7 + i, b + 5 + i, b + 4 + i, 0);
                n++;
                prog[n] = mk_uc(OP_X2, b + 7 + i, b + 7 + i, 0, 0);
                n++;
            end
            for (int i = 0; i < 10; i++)
            begin
                prog[n] = mk_uc(OP_SUB, b + 9, b + lp[i] + 1, b + lp[i], 0);
                n++;
                prog[n] = mk_uc(OP_MULU, b + 9, b + 9, 0, 0);
                n++;
                prog[n] = mk_uc(OP_ADD, b + lp[i], b + lp[i], b + 9, 0);
                n++;
            end
        end
        prog[n] = mk_uc(OP_LD, T0_ADDR, 0, 0, SRC_PX);       n++;
        prog[n] = mk_uc(OP_SUB, 0, 0, T0_ADDR, 0);           n++;
        prog[n] = mk_uc(OP_LD, T1_ADDR, 0, 0, SRC_PY);       n++;
        prog[n] = mk_uc(OP_SUB, 10, 10, T1_ADDR, 0);         n++;
        prog[n] = mk_uc(OP_MUL8, T0_ADDR, 0, 4, 0);          n++;
        prog[n] = mk_uc(OP_MUL8, T1_ADDR, 10, 14, 0);        n++;
        prog[n] = mk_uc(OP_ADD, NUM_IDX, T0_ADDR, T1_ADDR, 0); n++;
        prog[n] = mk_uc(OP_MUL8, T0_ADDR, 4, 4, 0);          n++;
        prog[n] = mk_uc(OP_MUL8, T1_ADDR, 14, 14, 0);        n++;
        prog[n] = mk_uc(OP_ADD, DEN_IDX, T0_ADDR, T1_ADDR, 0); n++;
        prog[n] = mk_uc(OP_MUL8, T0_ADDR, 0, 7, 0);          n++;
        prog[n] = mk_uc(OP_MUL8, T1_ADDR, 10, 17, 0);        n++;
        prog[n] = mk_uc(OP_ADD, T0_ADDR, T0_ADDR, T1_ADDR, 0); n++;
        prog[n] = mk_uc(OP_ADD, DEN_IDX, DEN_IDX, T0_ADDR, 0); n++;
        if (int'(pc) < UCODE_LEN)
            return prog[pc];
        else
            return mk_uc(OP_LD, 0, 0, 0, 0);
    endfunction

endpackage

[design/bnr_ram.sv]
// bnr_ram: generic RAM, one write port, two registered read ports.
// No dependencies.
module bnr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[design/bnr_ctrl.sv]
// bnr_ctrl: sequencer for the refiner; steps the microcode, multiplier and divider.
// Depends on bnr_pkg.
module bnr_ctrl
    import bnr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    output cmd_t  cmd,
    input  stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_MLO,
        S_MHI,
        S_MFIN,
        S_RDFIN,
        S_DLOAD,
        S_DIV,
        S_DFIN,
        S_COMMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [UPC_W-1:0] pc_reg, pc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    ucode_t           uc;
    logic             is_mul;
    logic             pc_end;

    assign uc     = ucode_rom(pc_reg);
    assign is_mul = (uc.op == OP_MULU) || (uc.op == OP_MUL8);
    assign pc_end = (pc_reg == UPC_W'(UCODE_LEN - 1));

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_FETCH;
                    pc_next    = '0;
                end
            end
            S_FETCH:
                state_next = S_EXEC;
            S_EXEC, S_MFIN:
            begin
                if (state_reg == S_EXEC && is_mul)
                    state_next = S_MLO;
                else if (pc_end)
                    state_next = S_RDFIN;
                else
                begin
                    state_next = S_FETCH;
                    pc_next    = pc_reg + 1'b1;
                end
            end
            S_MLO:
                state_next = S_MHI;
            S_MHI:
                state_next = S_MFIN;
            S_RDFIN:
                state_next = S_DLOAD;
            S_DLOAD:
            begin
                cnt_next   = '0;
                state_next = stat.den_zero ? S_DFIN : S_DIV;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                    state_next = S_DFIN;
            end
            S_DFIN:
                state_next = S_COMMIT;
            S_COMMIT:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.uc       = uc;
        cmd.load     = s_tvalid && s_tready;
        cmd.exec     = (state_reg == S_EXEC);
        cmd.mlo      = (state_reg == S_MLO);
        cmd.mhi      = (state_reg == S_MHI);
        cmd.mfin     = (state_reg == S_MFIN);
        cmd.div_load = (state_reg == S_DLOAD);
        cmd.div_step = (state_reg == S_DIV);
        cmd.div_fin  = (state_reg == S_DFIN);
        cmd.commit   = (state_reg == S_COMMIT) && stat.out_free;
        if (state_reg == S_RDFIN || state_reg == S_DLOAD)
        begin
            cmd.rd_a = NUM_ADDR;
            cmd.rd_b = DEN_ADDR;
        end
        else
        begin
            cmd.rd_a = uc.a;
            cmd.rd_b = uc.b;
        end
    end

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted but sequencer stayed idle");

    a_div_after_ucode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> pc_end)
        else $error("divider stepping before microcode finished");

endmodule

[design/bnr_dpath.sv]
// bnr_dpath: register file, shared 48x24 multiplier, serial divider and result stage.
// Depends on bnr_pkg and bnr_ram.
module bnr_dpath
    import bnr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int PARAM_WIDTH = PARAM_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    output stat_t                         stat,
    input  logic                          cfg_we,
    input  logic [CFG_AW-1:0]             cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [PARAM_WIDTH-1:0] old_param,
    input  logic                          is_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [PARAM_WIDTH-1:0]        new_param,
    output logic                          order_ok,
    output logic                          last_out
);

    localparam int DIFF_W = ACC_W + 2;

    logic signed [COORD_WIDTH-1:0] ctrl_reg [CFG_NUM];
    logic signed [COORD_WIDTH-1:0] px_reg, py_reg;
    logic signed [PARAM_WIDTH-1:0] u_reg;
    logic                          last_reg;

    logic [ACC_W-1:0]        rd_a, rd_b;
    logic signed [ACC_W-1:0] opa, opb;
    logic                    wr_en;
    logic [ACC_W-1:0]        wr_data;
    logic signed [ACC_W-1:0] alu_res;
    logic signed [ACC_W-1:0] ld_val;
    logic signed [ACC_W-1:0] u_ext;

    logic [ACC_W-1:0]        mx_reg, my_reg;
    logic                    mneg_reg, msh_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [HALF_W-1:0]       my_half;
    logic [ACC_W+HALF_W-1:0] mul_p;
    logic [PROD_W-1:0]       mq, mqi, mlim;
    logic                    mrem;
    logic [ACC_W-1:0]        mqs;
    logic [ACC_W-1:0]        mul_res;

    logic [DVD_W-1:0]  dvd_reg;
    logic [ACC_W-1:0]  dsr_reg, rem_reg;
    logic              qneg_reg, dz_reg;
    logic [ACC_W:0]    rem_sh;
    logic              ge;
    logic [ACC_W-1:0]  qm;
    logic signed [ACC_W-1:0]  step;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] pmax, pmin;
    logic signed [PARAM_WIDTH-1:0] res_reg, res_calc;

    logic signed [PARAM_WIDTH-1:0] prev_reg;
    logic                          flag_reg, start_reg;
    logic                          flag_new;
    logic                          ov_reg;
    logic [PARAM_WIDTH-1:0]        od_reg;
    logic                          ou_reg, ol_reg;

    function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] v);
        return v[ACC_W-1] ? ACC_W'(-v) : v;
    endfunction

    bnr_ram #(
        .WIDTH(ACC_W),
        .DEPTH(RF_DEPTH)
    ) u_rf (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (cmd.uc.dst),
        .wdata   (wr_data),
        .raddr_a (cmd.rd_a),
        .raddr_b (cmd.rd_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    assign opa   = $signed(rd_a);
    assign opb   = $signed(rd_b);
    assign u_ext = ACC_W'(u_reg);

    always_comb
    begin
        if (cmd.uc.k < K_W'(CFG_NUM))
            ld_val = ACC_W'(ctrl_reg[cmd.uc.k[CFG_AW-1:0]]);
        else if (cmd.uc.k == K_W'(SRC_PX))
            ld_val = ACC_W'(px_reg);
        else
            ld_val = ACC_W'(py_reg);
    end

    always_comb
    begin
        unique case (cmd.uc.op)
            OP_LD:   alu_res = ld_val;
            OP_SUB:  alu_res = sat_acc(EXT_W'(opa) - EXT_W'(opb));
            OP_ADD:  alu_res = sat_acc(EXT_W'(opa) + EXT_W'(opb));
            OP_X3:   alu_res = sat_acc(EXT_W'(opa) + (EXT_W'(opa) <<< 1));
            OP_X2:   alu_res = sat_acc(EXT_W'(opa) <<< 1);
            default: alu_res = opa;
        endcase
    end

    // floor(a*b / 2^sh) on magnitudes, rounded away for negatives, saturated
    assign my_half = cmd.mhi ? my_reg[ACC_W-1:HALF_W] : my_reg[HALF_W-1:0];
    assign mul_p   = mx_reg * my_half;
    assign mq      = msh_reg ? (prod_reg >> PARAM_FRAC) : (prod_reg >> COORD_FRAC);
    assign mrem    = msh_reg ? (|prod_reg[PARAM_FRAC-1:0]) : (|prod_reg[COORD_FRAC-1:0]);
    assign mqi     = mq + PROD_W'(mneg_reg && mrem);
    assign mlim    = PROD_W'(ACC_MAX) + PROD_W'(mneg_reg);
    assign mqs     = (mqi > mlim) ? mlim[ACC_W-1:0] : mqi[ACC_W-1:0];
    assign mul_res = mneg_reg ? ACC_W'(-mqs) : mqs;

    assign wr_en   = (cmd.exec && cmd.uc.op != OP_MULU && cmd.uc.op != OP_MUL8) || cmd.mfin;
    assign wr_data = cmd.mfin ? mul_res : alu_res;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg   <= point_x;
            py_reg   <= point_y;
            u_reg    <= old_param;
            last_reg <= is_last;
        end
        if (cmd.exec)
        begin
            mx_reg   <= mag(opa);
            my_reg   <= (cmd.uc.op == OP_MULU) ? mag(u_ext) : mag(opb);
            mneg_reg <= opa[ACC_W-1] ^ ((cmd.uc.op == OP_MULU) ? u_ext[ACC_W-1] : opb[ACC_W-1]);
            msh_reg  <= (cmd.uc.op == OP_MULU);
        end
        if (cmd.mlo)
            prod_reg <= PROD_W'(mul_p);
        else if (cmd.mhi)
            prod_reg <= prod_reg + (PROD_W'(mul_p) << HALF_W);
    end

    // restoring divider, one quotient bit per cycle
    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, dsr_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            dvd_reg  <= DVD_W'(mag(opa)) << PARAM_FRAC;
            dsr_reg  <= mag(opb);
            rem_reg  <= '0;
            qneg_reg <= opa[ACC_W-1] ^ opb[ACC_W-1];
            dz_reg   <= (opb == '0);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? ACC_W'(rem_sh - {1'b0, dsr_reg}) : rem_sh[ACC_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
        end
        if (cmd.div_fin)
            res_reg <= res_calc;
    end

    assign qm   = (dvd_reg > DVD_W'(ACC_MAX)) ? ACC_MAX : dvd_reg[ACC_W-1:0];
    assign step = qneg_reg ? $signed(ACC_W'(-qm)) : $signed(qm);
    assign diff = DIFF_W'(u_reg) - DIFF_W'(step);
    assign pmax = DIFF_W'($signed({1'b0, {(PARAM_WIDTH-1){1'b1}}}));
    assign pmin = DIFF_W'($signed({1'b1, {(PARAM_WIDTH-1){1'b0}}}));

    always_comb
    begin
        priority if (dz_reg)
            res_calc = u_reg;
        else if (diff > pmax)
            res_calc = pmax[PARAM_WIDTH-1:0];
        else if (diff < pmin)
            res_calc = pmin[PARAM_WIDTH-1:0];
        else
            res_calc = diff[PARAM_WIDTH-1:0];
    end

    assign flag_new = flag_reg && !(!start_reg && (res_reg <= prev_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_NUM; i++)
                ctrl_reg[i] <= '0;
            prev_reg  <= '0;
            flag_reg  <= 1'b1;
            start_reg <= 1'b1;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                ctrl_reg[cfg_index] <= cfg_data;
            if (cmd.commit)
            begin
                prev_reg  <= res_reg;
                flag_reg  <= last_reg ? 1'b1 : flag_new;
                start_reg <= last_reg;
                ov_reg    <= 1'b1;
            end
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            od_reg <= res_reg;
            ou_reg <= flag_new;
            ol_reg <= last_reg;
        end
    end

    assign stat.den_zero = (opb == '0);
    assign stat.out_free = !ov_reg || out_ready;

    assign out_valid = ov_reg;
    assign new_param = od_reg;
    assign order_ok  = ou_reg;
    assign last_out  = ol_reg;

    a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.exec, cmd.mlo, cmd.mhi, cmd.mfin, cmd.div_load, cmd.div_step,
                  cmd.div_fin, cmd.commit}))
        else $error("datapath given more than one command");

    a_no_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !dz_reg)
        else $error("divider stepping on a zero denominator");

    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |-> !cmd.commit)
        else $error("result overwritten before it was taken");

endmodule

[design/bezier_parameter_newton_refine_top.sv]
// bezier_parameter_newton_refine_top: one Newton step on a cubic Bezier curve parameter.
// Depends on bnr_pkg, bnr_ctrl, bnr_dpath, bnr_ram.
//
//   channel | direction | payload
//   s_*     | in        | tdata: point_x, point_y, old_param; tlast: is_last
//   m_*     | out       | tdata: new_param; tuser: order_ok; tlast: last_out
//   cfg_*   | in        | register index 0..7 (control points), data
//
// One request at a time: 102 microcode steps (a multiply runs on the shared 48x24
// multiplier), a restoring divider over a 64-bit dividend, skipped for a zero
// denominator, then the hand-off to the output register.
// A new request is taken as soon as the previous one reaches the output register;
// a stalled output holds the next result in the result register until the output register frees.
// Reset clears the control points and pass state.
module bezier_parameter_newton_refine_top
    import bnr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int PARAM_WIDTH = PARAM_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // point_x, point_y, old_param, zero fill
    input  logic [((2*COORD_WIDTH+PARAM_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // new_param, zero fill
    output logic [((PARAM_WIDTH+7)/8)*8-1:0]      m_tdata,
    // order_ok
    output logic                                  m_tuser,
    output logic                                  m_tlast,
    input  logic                                  cfg_we,
    input  logic [CFG_AW-1:0]                     cfg_index,
    input  logic [COORD_WIDTH-1:0]                cfg_data
);

    localparam int OUT_W = ((PARAM_WIDTH + 7) / 8) * 8;

    cmd_t                   cmd;
    stat_t                  stat;
    logic [PARAM_WIDTH-1:0] new_param;

    bnr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bnr_dpath #(
        .COORD_WIDTH(COORD_WIDTH),
        .PARAM_WIDTH(PARAM_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .point_x   ($signed(s_tdata[COORD_WIDTH-1:0])),
        .point_y   ($signed(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
        .old_param ($signed(s_tdata[2*COORD_WIDTH+PARAM_WIDTH-1:2*COORD_WIDTH])),
        .is_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .new_param (new_param),
        .order_ok  (m_tuser),
        .last_out  (m_tlast)
    );

    assign m_tdata = OUT_W'(new_param);

endmodule
